/* hdl/anbd_pkg.sv */
// ----------------------------------------------------------------------------
// Annex B deframer package
// Shared types and constants for the start-code and escape removal block.
// ----------------------------------------------------------------------------
package anbd_pkg;

    // Most results that a single input byte can cause.
    localparam int MAX_RESULTS = 5;
    localparam int COUNT_W     = $clog2(MAX_RESULTS + 1);

    // Codec mode register values. Any other value behaves as VVC.
    localparam logic [1:0] CODEC_AVC  = 2'd0;
    localparam logic [1:0] CODEC_HEVC = 2'd1;

    // Special byte values of the Annex B syntax.
    localparam logic [7:0] BYTE_ZERO   = 8'h00;
    localparam logic [7:0] BYTE_START  = 8'h01;
    localparam logic [7:0] BYTE_ESCAPE = 8'h03;

    // Unit type field masks of the header bytes.
    localparam logic [7:0] AVC_TYPE_MASK  = 8'h1f;
    localparam logic [7:0] HEVC_TYPE_MASK = 8'h7e;
    localparam logic [7:0] VVC_TYPE_MASK  = 8'hf8;

    typedef logic [1:0] codec_mode_t;

    typedef struct packed {
        logic [7:0] data_in;
        logic       end_of_stream;
    } anbd_item_t;

    typedef struct packed {
        logic [7:0] data_out;
        logic       header_flag;
        logic [5:0] unit_type;
        logic       first_of_unit;
        logic       last_of_unit;
        logic       last_of_run;
    } anbd_result_t;

    // Results of one input byte, handed from the core to the output queue.
    typedef struct packed {
        logic [COUNT_W-1:0]                   count;
        anbd_result_t [MAX_RESULTS-1:0]       results;
    } anbd_burst_t;

endpackage

/* hdl/anbd_chan_if.sv */
// ----------------------------------------------------------------------------
// Annex B deframer channel
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
interface anbd_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

/* hdl/anbd_core.sv */
// ----------------------------------------------------------------------------
// Annex B deframer core
// Input register, codec mode register and the single-pass byte parser.
// ----------------------------------------------------------------------------
module anbd_core
    import anbd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    anbd_chan_if.sink   cfg,
    anbd_chan_if.sink   stream,
    input  logic        room,
    output anbd_burst_t burst
);

    typedef struct packed {
        logic [1:0] held_zeros;
        logic [7:0] pending_value;
        logic       pending_valid;
        logic       pending_hdr;
        logic       pending_first;
        logic [1:0] header_position;
        logic [5:0] current_type;
        logic       unit_opening;
    } parse_state_t;

    typedef struct packed {
        parse_state_t                   st;
        anbd_result_t [MAX_RESULTS-1:0] res;
        logic [COUNT_W-1:0]             cnt;
    } work_t;

    localparam parse_state_t STATE_RESET = '{
        held_zeros: 2'd0, pending_value: 8'd0, pending_valid: 1'b0,
        pending_hdr: 1'b0, pending_first: 1'b0, header_position: 2'd0,
        current_type: 6'd0, unit_opening: 1'b1
    };

    function automatic logic [1:0] header_len(codec_mode_t mode);
        return (mode == CODEC_AVC) ? 2'd1 : 2'd2;
    endfunction

    function automatic work_t emit_pending(work_t w, logic last);
        work_t        o;
        anbd_result_t r;
        o               = w;
        r.data_out      = w.st.pending_value;
        r.header_flag   = w.st.pending_hdr;
        r.unit_type     = w.st.pending_hdr ? 6'd0 : w.st.current_type;
        r.first_of_unit = w.st.pending_first;
        r.last_of_unit  = last;
        r.last_of_run   = 1'b0;
        o.res[w.cnt]    = r;
        o.cnt           = w.cnt + 1'b1;
        o.st.pending_valid = 1'b0;
        return o;
    endfunction

    function automatic work_t push_byte(work_t w, logic [7:0] b, codec_mode_t mode);
        work_t      o;
        logic [7:0] masked;
        o = w;
        if (o.st.pending_valid)
        begin
            o = emit_pending(o, 1'b0);
        end
        o.st.pending_first = o.st.unit_opening;
        o.st.unit_opening  = 1'b0;
        o.st.pending_hdr   = 1'b0;
        if (o.st.header_position < header_len(mode))
        begin
            o.st.pending_hdr = 1'b1;
            if (mode == CODEC_AVC)
            begin
                masked = b & AVC_TYPE_MASK;
                o.st.current_type = masked[5:0];
            end
            else if (mode == CODEC_HEVC)
            begin
                masked = b & HEVC_TYPE_MASK;
                if (o.st.header_position == 2'd0)
                begin
                    o.st.current_type = masked[6:1];
                end
            end
            else
            begin
                // VVC takes the type from the second header byte.
                masked = b & VVC_TYPE_MASK;
                if (o.st.header_position == 2'd1)
                begin
                    o.st.current_type = {1'b0, masked[7:3]};
                end
            end
            o.st.header_position = o.st.header_position + 2'd1;
        end
        o.st.pending_value = b;
        o.st.pending_valid = 1'b1;
        return o;
    endfunction

    function automatic work_t flush_zeros(work_t w, codec_mode_t mode);
        work_t o;
        o = w;
        for (int i = 0; i < 3; i++)
        begin
            if (o.st.held_zeros != 2'd0)
            begin
                o = push_byte(o, BYTE_ZERO, mode);
                o.st.held_zeros = o.st.held_zeros - 2'd1;
            end
        end
        return o;
    endfunction

    codec_mode_t  codec_mode_reg;
    anbd_item_t   item_reg;
    logic         item_valid_reg;
    parse_state_t state_reg;

    logic         fire;
    logic         take;
    logic         item_valid_next;
    work_t        w;
    logic [1:0]   hl;
    logic [1:0]   rem;
    logic [1:0]   payload_zeros;

    assign cfg.ready    = 1'b1;
    assign fire         = item_valid_reg && room;
    assign stream.ready = !item_valid_reg || fire;
    assign take         = stream.valid && stream.ready;

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (take)
        begin
            item_valid_next = 1'b1;
        end
        else if (fire)
        begin
            item_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        w.st  = state_reg;
        w.res = '0;
        w.cnt = '0;
        hl    = header_len(codec_mode_reg);
        rem   = (hl > state_reg.header_position) ? hl - state_reg.header_position : 2'd0;
        payload_zeros = (state_reg.held_zeros > rem) ? state_reg.held_zeros - rem : 2'd0;

        priority if (item_reg.data_in == BYTE_ZERO)
        begin
            if (w.st.held_zeros == 2'd3)
            begin
                w = push_byte(w, BYTE_ZERO, codec_mode_reg);
            end
            else
            begin
                w.st.held_zeros = w.st.held_zeros + 2'd1;
            end
        end
        else if (item_reg.data_in == BYTE_START && w.st.held_zeros >= 2'd2)
        begin
            if (w.st.pending_valid)
            begin
                w = emit_pending(w, 1'b1);
            end
            w.st.held_zeros      = 2'd0;
            w.st.unit_opening    = 1'b1;
            w.st.header_position = 2'd0;
        end
        else if (item_reg.data_in == BYTE_ESCAPE && payload_zeros >= 2'd2)
        begin
            w = flush_zeros(w, codec_mode_reg);
        end
        else
        begin
            w = flush_zeros(w, codec_mode_reg);
            w = push_byte(w, item_reg.data_in, codec_mode_reg);
        end

        if (item_reg.end_of_stream)
        begin
            w = flush_zeros(w, codec_mode_reg);
            if (w.st.pending_valid)
            begin
                w = emit_pending(w, 1'b1);
            end
            w.st.unit_opening    = 1'b1;
            w.st.header_position = 2'd0;
            w.st.current_type    = 6'd0;
        end

        if (w.cnt != '0)
        begin
            w.res[w.cnt - 1'b1].last_of_run = 1'b1;
        end
    end

    assign burst.count   = fire ? w.cnt : '0;
    assign burst.results = w.res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            codec_mode_reg <= CODEC_AVC;
            item_valid_reg <= 1'b0;
            state_reg      <= STATE_RESET;
        end
        else
        begin
            if (cfg.valid)
            begin
                codec_mode_reg <= cfg.payload;
            end
            item_valid_reg <= item_valid_next;
            if (fire)
            begin
                state_reg <= w.st;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= stream.payload;
        end
    end

endmodule

/* hdl/anbd_queue.sv */
// ----------------------------------------------------------------------------
// Annex B deframer result queue
// Register queue that takes a burst of results and sends one per transfer.
// ----------------------------------------------------------------------------
module anbd_queue
    import anbd_pkg::*;
#(
    parameter int DEPTH = 8
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  anbd_burst_t  burst,
    output logic         room,
    anbd_chan_if.source  result
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W:0]   DEPTH_EXT = (IDX_W + 1)'(DEPTH);
    localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] ROOM_MAX  = CNT_W'(DEPTH - MAX_RESULTS);

    anbd_result_t     entry_reg [DEPTH];
    logic [IDX_W-1:0] head_reg;
    logic [IDX_W-1:0] tail_reg;
    logic [CNT_W-1:0] count_reg;

    logic [IDX_W-1:0] head_next;
    logic [IDX_W-1:0] tail_next;
    logic [CNT_W-1:0] count_next;
    logic [IDX_W-1:0] slot [MAX_RESULTS];
    logic [IDX_W:0]   slot_sum;
    logic [IDX_W:0]   tail_sum;
    logic             pop;

    assign room           = count_reg <= ROOM_MAX;
    assign result.valid   = count_reg != '0;
    assign result.payload = entry_reg[head_reg];
    assign pop            = result.valid && result.ready;

    always_comb
    begin
        slot_sum = '0;
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            slot_sum = {1'b0, tail_reg} + (IDX_W + 1)'(i);
            if (slot_sum >= DEPTH_EXT)
            begin
                slot_sum = slot_sum - DEPTH_EXT;
            end
            slot[i] = slot_sum[IDX_W-1:0];
        end

        tail_sum = {1'b0, tail_reg} + (IDX_W + 1)'(burst.count);
        if (tail_sum >= DEPTH_EXT)
        begin
            tail_sum = tail_sum - DEPTH_EXT;
        end
        tail_next = tail_sum[IDX_W-1:0];

        head_next = head_reg;
        if (pop)
        begin
            head_next = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
        end

        count_next = count_reg + CNT_W'(burst.count) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            if (COUNT_W'(i) < burst.count)
            begin
                entry_reg[slot[i]] <= burst.results[i];
            end
        end
    end

endmodule

/* hdl/annexb_nal_deframer.sv */
// ----------------------------------------------------------------------------
// Annex B NAL deframer
// Start-code removal and emulation-prevention removal for AVC, HEVC and VVC.
// ----------------------------------------------------------------------------
// The block takes one byte of an Annex B elementary stream per transfer on
// the stream channel and can accept a new byte in every clock cycle while
// the result queue has room. Each byte passes through an input register, is
// parsed against the held-zero and header state, and the zero to five
// results that it causes are written at once into a result queue of
// QUEUE_DEPTH entries. The result channel sends one result per cycle while
// the receiver is ready, so the sustained rate is one byte per cycle while
// bytes cause one result on average; a byte is taken into the parser only
// while the queue has room for five more results, which is what stalls the
// input after bursts such as flushed zero runs. A byte's results are offered
// on the result channel once they sit in the queue registers. The first
// result of every unit carries first_of_unit and header_flag; since the last
// byte of a unit is only known when the next start code or the end-of-stream
// flag arrives, the newest byte is held back until the following byte or
// the end-of-stream flag shows whether it ends its unit. Write codec_mode on
// the cfg channel only while the block is idle; it always takes the write.
// ----------------------------------------------------------------------------
module annexb_nal_deframer
    import anbd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    anbd_chan_if.sink   cfg,
    anbd_chan_if.sink   stream,
    anbd_chan_if.source result
);

    // Results of the byte in the parser and whether the queue can take them.
    anbd_burst_t burst;
    logic        room;

    anbd_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .stream (stream),
        .room   (room),
        .burst  (burst)
    );

    anbd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .burst  (burst),
        .room   (room),
        .result (result)
    );

endmodule

/* hdl/anbd_checker.sv */
// ----------------------------------------------------------------------------
// Annex B deframer checker
// Port-level assertions on the result channel of the deframer.
// ----------------------------------------------------------------------------
module anbd_checker
    import anbd_pkg::*;
(
    input logic         clk,
    input logic         rst_n,
    input logic         out_valid,
    input logic         out_ready,
    input anbd_result_t out_payload
);

    // A result that is not taken stays offered.
    a_valid_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result valid dropped while stalled");

    // A stalled result keeps its value.
    a_payload_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_payload))
        else $error("result payload changed while stalled");

    // Header bytes report a unit type of zero.
    a_header_type: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_payload.header_flag |-> out_payload.unit_type == 6'd0)
        else $error("header byte carries a unit type");

    // Every unit opens with a header byte.
    a_first_is_header: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_payload.first_of_unit |-> out_payload.header_flag)
        else $error("first byte of a unit is not a header byte");

endmodule

bind annexb_nal_deframer anbd_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .out_payload (result.payload)
);

/* test/tb_annexb_nal_deframer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Annex B NAL deframer testbench
// Feeds directed and random Annex B byte streams in every codec mode and
// checks each result against a cycle-free predictor of the deframer.
// ----------------------------------------------------------------------------
module tb_annexb_nal_deframer;
    import anbd_pkg::*;

    // The package names only the AVC and HEVC codes; VVC and the spare code
    // (which the block treats as VVC) are named here.
    localparam codec_mode_t CODEC_VVC   = 2'd2;
    localparam codec_mode_t CODEC_SPARE = 2'd3;

    localparam int SHOWN_MISMATCHES = 10;
    localparam int ITEMS_PER_PHASE  = 58;

    logic clk;
    logic rst_n;

    anbd_chan_if #(.payload_t(codec_mode_t))  cfg_if ();
    anbd_chan_if #(.payload_t(anbd_item_t))   stream_if ();
    anbd_chan_if #(.payload_t(anbd_result_t)) result_if ();

    annexb_nal_deframer u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_if),
        .stream (stream_if),
        .result (result_if)
    );

    // 100 MHz clock.
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------------
    // Predictor state. It mirrors the deframer: zeros held back until it is
    // known whether they start a start code, one byte held back so that the
    // last byte of a unit can be marked, and the header progress of the unit.
    // ------------------------------------------------------------------------
    codec_mode_t  mode;
    logic [1:0]   zeros_held;
    logic [7:0]   held_value;
    logic         held_valid;
    logic         held_header;
    logic         held_first;
    logic [1:0]   hdr_pos;
    logic [5:0]   cur_type;
    logic         opening;

    // Results caused by the byte being predicted, and the queue of results
    // that the block still owes, oldest first.
    anbd_result_t byte_results[$];
    anbd_result_t results_due[$];

    // Counters for checking and for the closing summary.
    int bytes_sent;
    int results_checked;
    int mismatches;
    int escapes_removed;
    int stream_ends;
    int units_opened;
    int burst_left;
    logic [3:0] modes_used;

    function automatic int header_bytes();
        return (mode == CODEC_AVC) ? 1 : 2;
    endfunction

    // The held byte leaves the block. Header bytes carry a unit type of zero.
    function automatic void release_held(input logic last);
        anbd_result_t r;
        r.data_out      = held_value;
        r.header_flag   = held_header;
        r.unit_type     = held_header ? 6'd0 : cur_type;
        r.first_of_unit = held_first;
        r.last_of_unit  = last;
        r.last_of_run   = 1'b0;
        byte_results = {byte_results, r};
        held_valid = 1'b0;
    endfunction

    // A byte of the unit becomes the new held byte; the one held before it
    // goes out, since it is now known not to be the last of its unit.
    function automatic void hold_byte(input logic [7:0] b);
        logic is_header;
        logic is_first;
        is_header = 1'b0;
        is_first  = opening;
        if (held_valid)
            release_held(1'b0);
        opening = 1'b0;
        if (int'(hdr_pos) < header_bytes())
        begin
            is_header = 1'b1;
            // The unit type sits in the first header byte for AVC and HEVC
            // and in the second one for VVC.
            if (mode == CODEC_AVC)
                cur_type = 6'(b & AVC_TYPE_MASK);
            else if (mode == CODEC_HEVC)
            begin
                if (hdr_pos == 2'd0)
                    cur_type = 6'((b & HEVC_TYPE_MASK) >> 1);
            end
            else if (hdr_pos == 2'd1)
                cur_type = 6'((b & VVC_TYPE_MASK) >> 3);
            hdr_pos++;
        end
        held_value  = b;
        held_header = is_header;
        held_first  = is_first;
        held_valid  = 1'b1;
    endfunction

    function automatic void flush_zeros();
        while (zeros_held != 2'd0)
        begin
            hold_byte(BYTE_ZERO);
            zeros_held--;
        end
    endfunction

    function automatic void clear_deframer();
        mode        = CODEC_AVC;
        zeros_held  = '0;
        held_value  = '0;
        held_valid  = 1'b0;
        held_header = 1'b0;
        held_first  = 1'b0;
        hdr_pos     = '0;
        cur_type    = '0;
        opening     = 1'b1;
    endfunction

    // Works out every result that one accepted stream byte causes and queues
    // them behind the results still owed.
    function automatic void deframe_byte(input anbd_item_t item);
        int rem;
        int payload_zeros;
        rem = (header_bytes() > int'(hdr_pos)) ? header_bytes() - int'(hdr_pos) : 0;
        payload_zeros = (int'(zeros_held) > rem) ? int'(zeros_held) - rem : 0;
        byte_results.delete();

        if (item.data_in == BYTE_ZERO)
        begin
            // A fourth zero pushes the oldest held zero out as data.
            if (zeros_held == 2'd3)
                hold_byte(BYTE_ZERO);
            else
                zeros_held++;
        end
        else if (item.data_in == BYTE_START && zeros_held >= 2'd2)
        begin
            // Start code: the held zeros are dropped and the held byte closes
            // the unit that is ending.
            if (held_valid)
                release_held(1'b1);
            zeros_held = '0;
            opening    = 1'b1;
            hdr_pos    = '0;
        end
        else if (item.data_in == BYTE_ESCAPE && payload_zeros >= 2)
        begin
            // Emulation prevention byte: the zeros stay, the escape goes.
            flush_zeros();
            escapes_removed++;
        end
        else
        begin
            flush_zeros();
            hold_byte(item.data_in);
        end

        if (item.end_of_stream)
        begin
            flush_zeros();
            if (held_valid)
                release_held(1'b1);
            opening  = 1'b1;
            hdr_pos  = '0;
            cur_type = '0;
            stream_ends++;
        end

        if (byte_results.size() > 0)
            byte_results[byte_results.size() - 1].last_of_run = 1'b1;
        results_due = {results_due, byte_results};
    endfunction

    // ------------------------------------------------------------------------
    // Result checker. Every transfer on the result channel is compared with
    // the oldest owed result, one field at a time.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        anbd_result_t got;
        anbd_result_t want;
        if (rst_n && result_if.valid && result_if.ready)
        begin
            got = result_if.payload;
            results_checked++;
            if (got.first_of_unit)
                units_opened++;
            if (results_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= SHOWN_MISMATCHES)
                    $display("%0t: unexpected result data %02h hdr %0b type %0d %s %0b %0b %0b",
                             $time, got.data_out, got.header_flag, got.unit_type,
                             "first/last/run", got.first_of_unit, got.last_of_unit,
                             got.last_of_run);
            end
            else
            begin
                want = results_due.pop_front();
                if (got.data_out      !== want.data_out      ||
                    got.header_flag   !== want.header_flag   ||
                    got.unit_type     !== want.unit_type     ||
                    got.first_of_unit !== want.first_of_unit ||
                    got.last_of_unit  !== want.last_of_unit  ||
                    got.last_of_run   !== want.last_of_run)
                begin
                    mismatches++;
                    if (mismatches <= SHOWN_MISMATCHES)
                    begin
                        $display("%0t: mismatch, expected data %02h hdr %0b type %0d %s %0b %0b %0b",
                                 $time, want.data_out, want.header_flag, want.unit_type,
                                 "first/last/run", want.first_of_unit, want.last_of_unit,
                                 want.last_of_run);
                        $display("%0t:           actual   data %02h hdr %0b type %0d %s %0b %0b %0b",
                                 $time, got.data_out, got.header_flag, got.unit_type,
                                 "first/last/run", got.first_of_unit, got.last_of_unit,
                                 got.last_of_run);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result receiver. Ready follows a 16-bit rotating pattern that is
    // reloaded whenever its random hold runs out: sometimes always ready,
    // sometimes mostly ready, sometimes mostly stalled.
    // ------------------------------------------------------------------------
    initial
    begin
        logic [15:0] ready_pattern;
        int          pattern_hold;
        ready_pattern   = 16'hffff;
        pattern_hold    = 0;
        result_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (pattern_hold == 0)
            begin
                pattern_hold = $urandom_range(40, 120);
                case ($urandom_range(3))
                    0:       ready_pattern = 16'hffff;
                    1:       ready_pattern = 16'($urandom);
                    2:       ready_pattern = 16'($urandom | $urandom);
                    default: ready_pattern = 16'($urandom & $urandom);
                endcase
                if (ready_pattern == '0)
                    ready_pattern = 16'h0001;
            end
            pattern_hold--;
            result_if.ready <= ready_pattern[0];
            ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
        end
    end

    // ------------------------------------------------------------------------
    // Stream sender. Bytes go out in bursts of random length; between bursts
    // valid drops for a random number of cycles, and some bursts follow each
    // other with no gap at all.
    // ------------------------------------------------------------------------
    task automatic stream_gap(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            stream_if.valid <= 1'b0;
        end
    endtask

    task automatic send_byte(input logic [7:0] value, input logic eos);
        anbd_item_t item;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(2) != 0)
                stream_gap($urandom_range(1, 6));
        end
        burst_left--;
        item.data_in       = value;
        item.end_of_stream = eos;
        @(negedge clk);
        stream_if.valid   <= 1'b1;
        stream_if.payload <= item;
        @(posedge clk);
        while (!stream_if.ready)
            @(posedge clk);
        deframe_byte(item);
        bytes_sent++;
    endtask

    // Holds the stream until every owed result has come, then waits out any
    // byte that owes nothing but may still be in flight.
    task automatic wait_drained();
        stream_gap(1);
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // The codec mode is only written while the block is idle.
    task automatic write_mode(input codec_mode_t m);
        wait_drained();
        @(negedge clk);
        cfg_if.valid   <= 1'b1;
        cfg_if.payload <= m;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        mode = m;
        modes_used[m] = 1'b1;
        @(negedge clk);
        cfg_if.valid <= 1'b0;
    endtask

    task automatic send_bytes(input logic [7:0] bytes[$], input logic eos_at_end);
        foreach (bytes[i])
            send_byte(bytes[i], eos_at_end && (i == bytes.size() - 1));
    endtask

    // Payload bytes lean toward zeros, escapes and start-code bytes so that
    // zero runs, escapes and false start codes turn up often.
    function automatic logic [7:0] payload_byte();
        case ($urandom_range(9))
            0, 1, 2: return BYTE_ZERO;
            3:       return BYTE_ESCAPE;
            4:       return BYTE_START;
            5:       return 8'h02;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // One well-formed unit: a three- or four-byte start code (now and then
    // with an extra leading zero), header bytes for the current mode, and a
    // payload of random length.
    task automatic send_unit(input logic eos_at_end);
        logic [7:0] bytes[$];
        int         prefix_zeros;
        int         payload_len;
        prefix_zeros = $urandom_range(2, 4);
        repeat (prefix_zeros)
            bytes = {bytes, BYTE_ZERO};
        bytes = {bytes, BYTE_START};
        repeat (header_bytes())
            bytes = {bytes, (($urandom_range(7) == 0) ? BYTE_ZERO : 8'($urandom_range(1, 255)))};
        payload_len = $urandom_range(0, 12);
        repeat (payload_len)
            bytes = {bytes, payload_byte()};
        send_bytes(bytes, eos_at_end);
    endtask

    // Unframed noise, with a rare end of stream in the middle of it.
    task automatic send_noise(input int count);
        repeat (count)
            send_byte(payload_byte(), $urandom_range(15) == 0);
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // AVC: bytes before the first start code, a four-byte start code, an
    // escape after two payload zeros, a fourth zero in a run, an empty unit,
    // and an end of stream that flushes a held zero.
    task automatic test_directed_avc();
        send_bytes('{8'hff, 8'h80, 8'h00, 8'h00, 8'h00, 8'h01}, 1'b0);
        send_bytes('{8'h65, 8'h00, 8'h00, 8'h03, 8'h01}, 1'b0);
        send_bytes('{8'h00, 8'h00, 8'h00, 8'h00, 8'h01}, 1'b0);
        send_bytes('{8'h00, 8'h00, 8'h01}, 1'b0);
        send_bytes('{8'h67, 8'h00}, 1'b1);
    endtask

    // HEVC: zeros in the two header bytes do not count toward an escape, so
    // the 03 that follows them is kept as payload.
    task automatic test_hevc_header_zeros();
        write_mode(CODEC_HEVC);
        send_bytes('{8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h03, 8'hff}, 1'b1);
    endtask

    // Random units and noise in one codec mode. The mode is written while the
    // previous unit is still open, so it takes effect in the middle of it.
    task automatic test_random_mode(input codec_mode_t m, input int items);
        int phase_start;
        write_mode(m);
        phase_start = bytes_sent;
        while (bytes_sent - phase_start < items)
        begin
            case ($urandom_range(9))
                7, 8:    send_noise($urandom_range(1, 6));
                9:       wait_drained();
                default: send_unit($urandom_range(5) == 0);
            endcase
        end
    endtask

    // Closes the stream so that nothing is left held inside the block.
    task automatic test_stream_end();
        send_unit(1'b1);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        rst_n             = 1'b0;
        cfg_if.valid      = 1'b0;
        cfg_if.payload    = '0;
        stream_if.valid   = 1'b0;
        stream_if.payload = '0;
        bytes_sent        = 0;
        results_checked   = 0;
        mismatches        = 0;
        escapes_removed   = 0;
        stream_ends       = 0;
        units_opened      = 0;
        burst_left        = 0;
        modes_used        = 4'b0001;
        clear_deframer();

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_avc();
        test_hevc_header_zeros();
        test_random_mode(CODEC_HEVC, ITEMS_PER_PHASE);
        test_random_mode(CODEC_VVC, ITEMS_PER_PHASE);
        test_random_mode(CODEC_SPARE, ITEMS_PER_PHASE);
        test_random_mode(CODEC_AVC, ITEMS_PER_PHASE);
        test_stream_end();

        // Let the owed results arrive, within a bound of its own.
        stream_gap(1);
        for (int i = 0; i < 20000 && results_due.size() != 0; i++)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (results_due.size() != 0)
            $display("%0d expected results never arrived", results_due.size());
        $display("Sent %0d stream bytes in codec modes %b, %0d stream ends; checked %0d results",
                 bytes_sent, modes_used, stream_ends, results_checked);
        $display("across %0d units, with %0d escape bytes removed; %0d mismatches",
                 units_opened, escapes_removed, mismatches);
        if (mismatches == 0 && results_due.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog: far longer than the slowest correct run needs.
    initial
    begin
        #2_000_000;
        $display("Timeout with %0d results still owed", results_due.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule
